@@ src/csx_pkg.sv @@
// ----------------------------------------------------------------------------
// csx_pkg: shared widths and types for the circle scan-row extents block
// Coordinate widths, the beat layouts and the sideband that rides alongside
// the root pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csx_pkg;

  // coordinate width of the centre fields
  localparam int COORD_BITS  = 12;

  localparam int IN_W        = COORD_BITS;          // centre x / y
  localparam int LEN_W       = COORD_BITS - 1;      // radius, offset, root
  localparam int OUT_W       = COORD_BITS + 1;      // result coordinates
  localparam int SQ_W        = 2 * LEN_W;           // squared lengths
  localparam int REM_W       = LEN_W + 2;           // root remainder

  localparam int IN_FIELDS_W = 2 * IN_W + 2 * LEN_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 4 * OUT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  // bit offsets of the input fields in tdata
  localparam int CX_LSB      = 0;
  localparam int CY_LSB      = CX_LSB + IN_W;
  localparam int RAD_LSB     = CY_LSB + IN_W;
  localparam int OFS_LSB     = RAD_LSB + LEN_W;

  // values that travel beside the root, unchanged by it
  typedef struct packed {
    logic [IN_W-1:0]  cx;
    logic [OUT_W-1:0] upper_y;
    logic [OUT_W-1:0] lower_y;
    logic             over;
  } side_t;

endpackage

`default_nettype wire

@@ src/csx_root.sv @@
// ----------------------------------------------------------------------------
// csx_root: pipelined integer square root
// One result bit per stage, restoring digit recurrence, with the sideband
// carried in step. All stages advance together on adv.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csx_root import csx_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             in_valid,
  input  wire logic [SQ_W-1:0]  in_rad,
  input  wire side_t            in_side,
  output logic                  out_valid,
  output logic [LEN_W-1:0]      out_root,
  output side_t                 out_side
);

  logic             valid_r  [LEN_W];
  logic [REM_W-1:0] rem_r    [LEN_W];
  logic [LEN_W-1:0] root_r   [LEN_W];
  logic [SQ_W-1:0]  rad_r    [LEN_W];
  side_t            side_r   [LEN_W];

  logic             valid_nxt [LEN_W];
  logic [REM_W-1:0] rem_nxt   [LEN_W];
  logic [LEN_W-1:0] root_nxt  [LEN_W];
  logic [SQ_W-1:0]  rad_nxt   [LEN_W];
  side_t            side_nxt  [LEN_W];

  // one digit step per stage: bring down two radicand bits, try root*4+1
  always_comb begin
    logic [REM_W-1:0] rem_in;
    logic [LEN_W-1:0] root_in;
    logic [SQ_W-1:0]  rad_in;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;
    for (int k = 0; k < LEN_W; k++) begin
      if (k == 0) begin
        rem_in       = '0;
        root_in      = '0;
        rad_in       = in_rad;
        valid_nxt[k] = in_valid;
        side_nxt[k]  = in_side;
      end else begin
        rem_in       = rem_r[k-1];
        root_in      = root_r[k-1];
        rad_in       = rad_r[k-1];
        valid_nxt[k] = valid_r[k-1];
        side_nxt[k]  = side_r[k-1];
      end
      rem_sh      = {rem_in[REM_W-3:0], rad_in[SQ_W-1:SQ_W-2]};
      trial       = {root_in, 2'b01};
      ge          = (rem_sh >= trial);
      rem_nxt[k]  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt[k] = {root_in[LEN_W-2:0], ge};
      rad_nxt[k]  = {rad_in[SQ_W-3:0], 2'b00};
    end
  end

  // advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LEN_W; k++) valid_r[k] <= 1'b0;
    end else if (adv) begin
      for (int k = 0; k < LEN_W; k++) valid_r[k] <= valid_nxt[k];
    end
  end

  // advance the stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < LEN_W; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        rad_r[k]  <= rad_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign out_valid = valid_r[LEN_W-1];
  assign out_root  = root_r[LEN_W-1];
  assign out_side  = side_r[LEN_W-1];

endmodule

`default_nettype wire

@@ src/circle_scanline_extents.sv @@
// ----------------------------------------------------------------------------
// circle_scanline_extents: span ends and mirrored rows of one circle scan row
// Squares radius and offset, takes the floored root of their difference (zero
// past the radius) and returns centre x -/+ root on rows centre y -/+ offset.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents
//  --------+-----+---------------------------------------------------------
//  in_*    | in  | tdata: center_x, center_y, radius, row_offset
//  out_*   | out | tdata: left_x, right_x, upper_y, lower_y; tuser: range flag
//
//  One beat per clock is accepted while the output register is free or being
//  emptied. The pipeline has one multiply stage, one subtract stage, one stage
//  per root bit in the square-root pipeline and one output stage.
//  rst_n clears the valid bits only. When the output register holds a beat
//  that is not taken, the whole pipeline holds and in_tready drops.
//
`timescale 1ns / 1ps
`default_nettype none

module circle_scanline_extents import csx_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // center_x, center_y, radius, row_offset, zero pad
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // left_x, right_x, upper_y, lower_y, zero pad
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // out_of_range
  output logic                        out_tuser
);

  logic adv;

  logic [IN_W-1:0]  cx;
  logic [IN_W-1:0]  cy;
  logic [LEN_W-1:0] rad;
  logic [LEN_W-1:0] ofs;

  logic             a_valid_r;
  logic [SQ_W-1:0]  a_rr_r,   a_rr_nxt;
  logic [SQ_W-1:0]  a_dd_r,   a_dd_nxt;
  side_t            a_side_r, a_side_nxt;

  logic             b_valid_r;
  logic [SQ_W-1:0]  b_rad_r,  b_rad_nxt;
  side_t            b_side_r;

  logic             root_valid;
  logic [LEN_W-1:0] root;
  side_t            root_side;

  logic             out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic             out_tuser_r;

  // move everything when the output register is free or being emptied
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  assign cx  = in_tdata[CX_LSB  +: IN_W];
  assign cy  = in_tdata[CY_LSB  +: IN_W];
  assign rad = in_tdata[RAD_LSB +: LEN_W];
  assign ofs = in_tdata[OFS_LSB +: LEN_W];

  // stage A: squares, range flag and the two rows
  always_comb begin
    a_rr_nxt           = SQ_W'(rad) * SQ_W'(rad);
    a_dd_nxt           = SQ_W'(ofs) * SQ_W'(ofs);
    a_side_nxt.cx      = cx;
    a_side_nxt.upper_y = {cy[IN_W-1], cy} - {2'b00, ofs};
    a_side_nxt.lower_y = {cy[IN_W-1], cy} + {2'b00, ofs};
    a_side_nxt.over    = (ofs > rad);
  end

  // stage B: radicand, forced to zero past the radius
  assign b_rad_nxt = a_side_r.over ? '0 : (a_rr_r - a_dd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= in_tvalid;
      b_valid_r   <= a_valid_r;
      out_valid_r <= root_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_rr_r      <= a_rr_nxt;
      a_dd_r      <= a_dd_nxt;
      a_side_r    <= a_side_nxt;
      b_rad_r     <= b_rad_nxt;
      b_side_r    <= a_side_r;
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= root_side.over;
    end
  end

  csx_root u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (b_valid_r),
    .in_rad    (b_rad_r),
    .in_side   (b_side_r),
    .out_valid (root_valid),
    .out_root  (root),
    .out_side  (root_side)
  );

  // output stage: span ends around the centre
  always_comb begin
    logic [OUT_W-1:0] left_x;
    logic [OUT_W-1:0] right_x;
    left_x        = {root_side.cx[IN_W-1], root_side.cx} - {2'b00, root};
    right_x       = {root_side.cx[IN_W-1], root_side.cx} + {2'b00, root};
    out_tdata_nxt = OUT_TDATA_W'({root_side.lower_y, root_side.upper_y, right_x, left_x});
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire
